### rtl/agr_pkg.sv
// ----------------------------------------------------------------------------
// agr_pkg
// Shared types, constants and gain table for the auto-ranging gain control.
// ----------------------------------------------------------------------------
package agr_pkg;

  localparam int SAMPLE_W        = 16;   // width of sample, threshold, measurement fields
  localparam int SAMPLE_BITS_DEF = 16;   // default significant sample bits
  localparam int GAIN_W          = 4;
  localparam int SETTLE_W        = 4;
  localparam int CFG_IDX_W       = 1;

  localparam logic [GAIN_W-1:0]   POS_RESET    = 4'd8;   // gain code one
  localparam logic [GAIN_W-1:0]   POS_TOP      = 4'd15;
  localparam logic [GAIN_W-1:0]   POS_NEAR_TOP = 4'd14;
  localparam logic [GAIN_W-1:0]   POS_MID_TOP  = 4'd13;
  localparam logic [GAIN_W-1:0]   POS_FLOOR    = 4'd1;
  localparam logic [SETTLE_W-1:0] SETTLE_LONG  = 4'd10;
  localparam logic [SETTLE_W-1:0] SETTLE_SHORT = 4'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR  = 1'd1;

  localparam logic MODE_BEGIN  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_RANGING = 2'd1,
    PH_MEASURE = 2'd2
  } agr_phase_t;

  typedef struct packed {
    logic                mode;
    logic [GAIN_W-1:0]   requested_gain;
    logic                auto_enable;
    logic [SAMPLE_W-1:0] adc_sample;
  } agr_in_t;

  typedef struct packed {
    logic [GAIN_W-1:0]   gain_code;
    logic                gain_update;
    logic                measurement_valid;
    logic [SAMPLE_W-1:0] measurement;
    logic                extrapolate_flag;
    logic [SETTLE_W-1:0] settle_count;
    logic                ranging_busy;
  } agr_out_t;

  typedef struct packed {
    agr_phase_t          phase;
    logic [GAIN_W-1:0]   position;
    logic [GAIN_W-1:0]   earlier_position;
    logic                changed_mark;
    logic                extrapolate_mark;
    logic [SETTLE_W-1:0] settle_value;
  } agr_state_t;

  // Position to preamp gain code.
  function automatic logic [GAIN_W-1:0] code_of_pos(input logic [GAIN_W-1:0] pos);
    logic [GAIN_W-1:0] code;
    case (pos)
      4'd0:    code = 4'd0;
      4'd1:    code = 4'd15;
      4'd2:    code = 4'd7;
      4'd3:    code = 4'd11;
      4'd4:    code = 4'd3;
      4'd5:    code = 4'd13;
      4'd6:    code = 4'd5;
      4'd7:    code = 4'd9;
      4'd8:    code = 4'd1;
      4'd9:    code = 4'd14;
      4'd10:   code = 4'd6;
      4'd11:   code = 4'd10;
      4'd12:   code = 4'd2;
      4'd13:   code = 4'd12;
      4'd14:   code = 4'd4;
      default: code = 4'd8;
    endcase
    return code;
  endfunction

  // Gain code to position (inverse of the table above).
  function automatic logic [GAIN_W-1:0] pos_of_code(input logic [GAIN_W-1:0] code);
    logic [GAIN_W-1:0] pos;
    case (code)
      4'd0:    pos = 4'd0;
      4'd15:   pos = 4'd1;
      4'd7:    pos = 4'd2;
      4'd11:   pos = 4'd3;
      4'd3:    pos = 4'd4;
      4'd13:   pos = 4'd5;
      4'd5:    pos = 4'd6;
      4'd9:    pos = 4'd7;
      4'd1:    pos = 4'd8;
      4'd14:   pos = 4'd9;
      4'd6:    pos = 4'd10;
      4'd10:   pos = 4'd11;
      4'd2:    pos = 4'd12;
      4'd12:   pos = 4'd13;
      4'd4:    pos = 4'd14;
      default: pos = 4'd15;
    endcase
    return pos;
  endfunction

endpackage

### rtl/agr_cfg.sv
// ----------------------------------------------------------------------------
// agr_cfg
// Threshold registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module agr_cfg
  import agr_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [SAMPLE_W-1:0]  wr_data,
  output logic [((SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W)-1:0] high_thr,
  output logic [((SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W)-1:0] low_thr
);

  localparam int EFF_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

  logic [EFF_BITS-1:0] high_thr_r;
  logic [EFF_BITS-1:0] low_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_thr_r <= '1;
      low_thr_r  <= '0;
    end else if (wr_en) begin
      case (wr_index)
        CFG_HIGH_THR: high_thr_r <= wr_data[EFF_BITS-1:0];
        CFG_LOW_THR:  low_thr_r  <= wr_data[EFF_BITS-1:0];
        default:      ;
      endcase
    end
  end

  assign high_thr = high_thr_r;
  assign low_thr  = low_thr_r;

endmodule

### rtl/agr_step.sv
// ----------------------------------------------------------------------------
// agr_step
// Next ranging state and result for one transaction.
// ----------------------------------------------------------------------------
module agr_step
  import agr_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  agr_state_t st,
  input  agr_in_t    item,
  input  logic [((SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W)-1:0] high_thr,
  input  logic [((SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W)-1:0] low_thr,
  output agr_state_t st_nxt,
  output agr_out_t   res
);

  localparam int EFF_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

  logic [EFF_BITS-1:0] sample;
  logic                step_down;
  logic                step_up;
  logic                meas_valid;

  assign sample    = item.adc_sample[EFF_BITS-1:0];
  assign step_down = (sample >= high_thr) && (st.position > POS_FLOOR);
  assign step_up   = (sample <= low_thr) && (st.position < POS_TOP);

  always_comb begin
    st_nxt     = st;
    meas_valid = 1'b0;
    if (item.mode == MODE_BEGIN) begin
      // abandon anything in flight and start afresh
      st_nxt.changed_mark     = 1'b0;
      st_nxt.earlier_position = '0;
      if (item.auto_enable) begin
        st_nxt.phase = PH_RANGING;
      end else begin
        st_nxt.position = pos_of_code(item.requested_gain);
        st_nxt.phase    = PH_MEASURE;
      end
    end else begin
      case (st.phase)
        PH_RANGING: begin
          if (step_down) begin
            st_nxt.changed_mark     = 1'b1;
            st_nxt.earlier_position = st.position;
            st_nxt.position         = st.position - 4'd1;
          end else if (step_up) begin
            st_nxt.changed_mark = 1'b1;
            st_nxt.position     = st.position + 4'd1;
          end else begin
            st_nxt.phase = PH_MEASURE;
          end
        end
        PH_MEASURE: begin
          meas_valid = 1'b1;
          if (st.changed_mark) begin
            if (st.position == POS_TOP || st.earlier_position == POS_TOP) begin
              st_nxt.settle_value     = SETTLE_LONG;
              st_nxt.extrapolate_mark = 1'b1;
            end else if (st.position == POS_NEAR_TOP || st.position == POS_MID_TOP) begin
              st_nxt.settle_value     = SETTLE_SHORT;
              st_nxt.extrapolate_mark = 1'b1;
            end
            st_nxt.changed_mark = 1'b0;
          end
          st_nxt.phase = PH_IDLE;
        end
        default: ;  // sample while idle: drop it
      endcase
    end
  end

  always_comb begin
    res.gain_code         = code_of_pos(st_nxt.position);
    // table is a permutation, so a code change is a position change
    res.gain_update       = (st_nxt.position != st.position);
    res.measurement_valid = meas_valid;
    res.measurement       = meas_valid ? SAMPLE_W'(sample) : '0;
    res.extrapolate_flag  = st_nxt.extrapolate_mark;
    res.settle_count      = st_nxt.settle_value;
    res.ranging_busy      = (st_nxt.phase == PH_RANGING);
  end

endmodule

### rtl/photometer_auto_gain_ranging.sv
// An accepted transaction waits in the input register; its result is then held in the output register.
// Throughput: 1 transaction per cycle; the input register and the output register
//   form a two-entry pipeline, so a waiting result stalls the input only once the
//   input register is full as well.
// Reset (rst_n low, synchronous): pipeline empty, phase idle, position 8 (gain code 1),
//   marks and settle count cleared, high threshold all ones, low threshold zero.
// ----------------------------------------------------------------------------
// photometer_auto_gain_ranging
// Auto-ranging preamp gain control with settle and extrapolation bookkeeping.
// ----------------------------------------------------------------------------
module photometer_auto_gain_ranging
  import agr_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  agr_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output agr_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SAMPLE_W-1:0]  cfg_data
);

  localparam int EFF_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

  logic [EFF_BITS-1:0] high_thr;
  logic [EFF_BITS-1:0] low_thr;

  logic       s1_valid_r;
  agr_in_t    s1_data_r;
  logic       out_valid_r;
  agr_out_t   out_data_r;
  agr_state_t st_r;
  agr_state_t st_nxt;
  agr_out_t   res;
  logic       out_free;
  logic       advance;
  logic       in_take;

  assign cfg_ready = 1'b1;

  agr_cfg #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .high_thr (high_thr),
    .low_thr  (low_thr)
  );

  agr_step #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_step (
    .st       (st_r),
    .item     (s1_data_r),
    .high_thr (high_thr),
    .low_thr  (low_thr),
    .st_nxt   (st_nxt),
    .res      (res)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
  end

  // ranging state, updated as each transaction leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase            <= PH_IDLE;
      st_r.position         <= POS_RESET;
      st_r.earlier_position <= '0;
      st_r.changed_mark     <= 1'b0;
      st_r.extrapolate_mark <= 1'b0;
      st_r.settle_value     <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_advance_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("transaction left input register but no result is held");

  a_extrapolate_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.extrapolate_mark |=> st_r.extrapolate_mark)
    else $error("extrapolate mark cleared without reset");

  a_settle_legal: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.settle_value == '0 || st_r.settle_value == SETTLE_SHORT ||
    st_r.settle_value == SETTLE_LONG)
    else $error("settle value outside its legal set");

  a_meas_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.measurement_valid) |-> !out_data_r.ranging_busy)
    else $error("measurement reported while ranging");

endmodule
